// ===== design/apsp_pkg.sv =====
// ----------------------------------------------------------------------------
// apsp_pkg
// shared types, constants and the microprogram of the shortest path engine
// ----------------------------------------------------------------------------
package apsp_pkg;

  localparam int DIST_W         = 21;
  localparam logic [DIST_W-1:0] DIST_MAX = 21'h1FFFFF;
  localparam int WEIGHT_FIELD_W = 16;
  localparam int IN_TDATA_W     = 32;
  localparam int OUT_TDATA_W    = 32;
  localparam int VIA_FIELD_W    = 5;
  localparam int VCOUNT_W       = 6;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_EDGE  = 2'd1,
    OP_RUN   = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_RST    = 4'd0,
    S_IDLE   = 4'd1,
    S_CLR    = 4'd2,
    S_EDGE   = 4'd3,
    S_QRD    = 4'd4,
    S_QEMIT  = 4'd5,
    S_RUN    = 4'd6,
    S_KLOOP  = 4'd7,
    S_IRD    = 4'd8,
    S_ILATCH = 4'd9,
    S_JRD    = 4'd10,
    S_JLATCH = 4'd11,
    S_JUPD   = 4'd12,
    S_INEXT  = 4'd13,
    S_KNEXT  = 4'd14,
    S_EMIT   = 4'd15
  } step_t;

  typedef enum logic [2:0] {
    A_ITEM  = 3'd0,
    A_IK    = 3'd1,
    A_KJ    = 3'd2,
    A_IJ    = 3'd3,
    A_SWEEP = 3'd4
  } addr_sel_t;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_CLEAR = 2'd1,
    WR_EDGE  = 2'd2,
    WR_RELAX = 2'd3
  } wr_t;

  typedef enum logic [1:0] {
    LAT_NONE = 2'd0,
    LAT_DIK  = 2'd1,
    LAT_DKJ  = 2'd2
  } lat_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_CLR  = 2'd1,
    CNT_INC  = 2'd2
  } cnt_op_t;

  typedef enum logic [3:0] {
    BR_NONE       = 4'd0,
    BR_ALWAYS     = 4'd1,
    BR_SWEEP_MORE = 4'd2,
    BR_DIK_OK     = 4'd3,
    BR_J_MORE     = 4'd4,
    BR_I_MORE     = 4'd5,
    BR_K_MORE     = 4'd6,
    BR_OUT_FREE   = 4'd7,
    BR_IN_VALID   = 4'd8
  } br_t;

  typedef enum logic [1:0] {
    EM_NONE  = 2'd0,
    EM_ZERO  = 2'd1,
    EM_QUERY = 2'd2
  } emit_t;

  typedef struct packed {
    logic      ready;
    logic      dispatch;
    addr_sel_t asel;
    wr_t       wr;
    lat_t      lat;
    cnt_op_t   k_op;
    cnt_op_t   i_op;
    cnt_op_t   j_op;
    logic      sweep_inc;
    br_t       br;
    logic      br_inv;
    logic      hold;
    emit_t     emit;
    step_t     target;
  } ucode_t;

  function automatic step_t dispatch_target(op_t op);
    step_t t;
    t = S_EMIT;
    unique case (op)
      OP_CLEAR: t = S_CLR;
      OP_EDGE:  t = S_EDGE;
      OP_RUN:   t = S_RUN;
      OP_QUERY: t = S_QRD;
    endcase
    return t;
  endfunction

  function automatic ucode_t ucode(step_t s);
    ucode_t w;
    w = '0;
    unique case (s)
      S_RST: begin
        w.asel = A_SWEEP; w.wr = WR_CLEAR; w.sweep_inc = 1'b1;
        w.br = BR_SWEEP_MORE; w.br_inv = 1'b1; w.hold = 1'b1; w.target = S_IDLE;
      end
      S_IDLE: begin
        w.ready = 1'b1; w.br = BR_IN_VALID; w.dispatch = 1'b1; w.hold = 1'b1;
      end
      S_CLR: begin
        w.asel = A_SWEEP; w.wr = WR_CLEAR; w.sweep_inc = 1'b1;
        w.br = BR_SWEEP_MORE; w.br_inv = 1'b1; w.hold = 1'b1; w.target = S_EMIT;
      end
      S_EDGE: begin
        w.asel = A_ITEM; w.wr = WR_EDGE; w.br = BR_ALWAYS; w.target = S_EMIT;
      end
      S_QRD: begin
        w.asel = A_ITEM;
      end
      S_QEMIT: begin
        w.asel = A_ITEM; w.emit = EM_QUERY;
        w.br = BR_OUT_FREE; w.hold = 1'b1; w.target = S_IDLE;
      end
      S_RUN: begin
        w.k_op = CNT_CLR;
      end
      S_KLOOP: begin
        w.i_op = CNT_CLR;
      end
      S_IRD: begin
        w.asel = A_IK;
      end
      S_ILATCH: begin
        w.lat = LAT_DIK; w.j_op = CNT_CLR;
        w.br = BR_DIK_OK; w.br_inv = 1'b1; w.target = S_INEXT;
      end
      S_JRD: begin
        w.asel = A_KJ;
      end
      S_JLATCH: begin
        w.asel = A_IJ; w.lat = LAT_DKJ;
      end
      S_JUPD: begin
        w.asel = A_IJ; w.wr = WR_RELAX; w.j_op = CNT_INC;
        w.br = BR_J_MORE; w.target = S_JRD;
      end
      S_INEXT: begin
        w.i_op = CNT_INC; w.br = BR_I_MORE; w.target = S_IRD;
      end
      S_KNEXT: begin
        w.k_op = CNT_INC; w.br = BR_K_MORE; w.target = S_KLOOP;
      end
      S_EMIT: begin
        w.emit = EM_ZERO; w.br = BR_OUT_FREE; w.hold = 1'b1; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== design/apsp_ram.sv =====
// ----------------------------------------------------------------------------
// apsp_ram
// single-port store with registered read data
// ----------------------------------------------------------------------------
module apsp_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/all_pairs_shortest_path_core.sv =====
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_core
// floyd-warshall engine over a directed graph, driven by a microcoded sequencer
// ----------------------------------------------------------------------------
// One item at a time; each item gives one result. After reset the distance and
// intermediate stores are swept clean, one entry per cycle over
// 2^(2*clog2(MAX_VERTICES)) entries (1024 at the default), and no item is taken
// meanwhile. An edge write is one store write, a query one store read, and a
// clear repeats the same sweep. A run relaxes over the n vertices in use, skipping
// a row whose first leg is unreachable; the single-port store allows one access per
// cycle and each relaxed cell needs two reads and a write. A finished result is
// held in an output register, and the next item is accepted while it waits.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_core #(
  parameter int MAX_VERTICES = 32,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [apsp_pkg::VCOUNT_W-1:0]         cfg_data,      // vertex_count
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [apsp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // src, dst, weight
  input  logic [1:0]                            s_axis_tuser,  // op
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // reachable, distance, has_intermediate, via_vertex, done_res
  output logic [apsp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

  import apsp_pkg::*;

  localparam int IDX_W   = $clog2(MAX_VERTICES);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DROW_W  = DIST_W + 1;
  localparam int VROW_W  = IDX_W + 1;
  localparam logic [WEIGHT_FIELD_W-1:0] WMASK = (WEIGHT_BITS >= WEIGHT_FIELD_W) ?
      {WEIGHT_FIELD_W{1'b1}} : WEIGHT_FIELD_W'((64'd1 << WEIGHT_BITS) - 64'd1);

  step_t                     pc;
  step_t                     pc_next;
  ucode_t                    cw;
  logic [ADDR_W-1:0]         sweep;
  logic [IDX_W-1:0]          k;
  logic [IDX_W-1:0]          i;
  logic [IDX_W-1:0]          j;
  logic [VCOUNT_W-1:0]       vertex_count;
  logic [IDX_W-1:0]          n_last;
  logic [4:0]                src;
  logic [4:0]                dst;
  logic [WEIGHT_FIELD_W-1:0] weight;
  logic                      dik_ok;
  logic [DIST_W-1:0]         dik_val;
  logic                      dkj_ok;
  logic [DIST_W-1:0]         dkj_val;
  logic                      out_valid;
  logic [OUT_TDATA_W-1:0]    out_data;

  logic                      accept;
  logic                      out_free;
  logic                      emit_fire;
  logic                      cond;
  logic                      taken;
  logic                      pair_ok;
  logic                      edge_ok;
  logic [WEIGHT_FIELD_W-1:0] w_eff;
  logic [DIST_W:0]           sum;
  logic [DIST_W-1:0]         sum_sat;
  logic                      better;
  logic [ADDR_W-1:0]         addr;
  logic                      dist_we;
  logic                      via_we;
  logic [DROW_W-1:0]         dist_wd;
  logic [VROW_W-1:0]         via_wd;
  logic [DROW_W-1:0]         dist_rd;
  logic [VROW_W-1:0]         via_rd;
  logic                      q_reach;
  logic                      q_via;
  logic [OUT_TDATA_W-1:0]    emit_data;

  // active vertex range
  always_comb begin
    if (vertex_count == '0) begin
      n_last = '0;
    end else if ({1'b0, vertex_count} >= 7'(MAX_VERTICES)) begin
      n_last = IDX_W'(MAX_VERTICES - 1);
    end else begin
      n_last = IDX_W'(vertex_count - 6'd1);
    end
  end

  assign cw            = ucode(pc);
  assign s_axis_tready = cw.ready;
  assign cfg_ready     = 1'b1;
  assign accept        = s_axis_tvalid && cw.ready;
  assign out_free      = !out_valid || m_axis_tready;
  assign emit_fire     = (cw.emit != EM_NONE) && out_free;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign pair_ok = (7'(src) <= 7'(n_last)) && (7'(dst) <= 7'(n_last));
  assign w_eff   = weight & WMASK;
  assign edge_ok = pair_ok && (w_eff != '0);

  // relaxation datapath
  assign sum     = {1'b0, dik_val} + {1'b0, dkj_val};
  assign sum_sat = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_W-1:0];
  assign better  = dkj_ok && (!dist_rd[DIST_W] || (sum_sat < dist_rd[DIST_W-1:0]));

  always_comb begin
    unique case (cw.br)
      BR_NONE:       cond = 1'b0;
      BR_ALWAYS:     cond = 1'b1;
      BR_SWEEP_MORE: cond = (sweep != '1);
      BR_DIK_OK:     cond = dist_rd[DIST_W];
      BR_J_MORE:     cond = (j != n_last);
      BR_I_MORE:     cond = (i != n_last);
      BR_K_MORE:     cond = (k != n_last);
      BR_OUT_FREE:   cond = out_free;
      BR_IN_VALID:   cond = s_axis_tvalid;
      default:       cond = 1'b0;
    endcase
    taken = (cw.br != BR_NONE) && (cond ^ cw.br_inv);
    if (taken) begin
      pc_next = cw.dispatch ? dispatch_target(op_t'(s_axis_tuser)) : cw.target;
    end else if (cw.hold) begin
      pc_next = pc;
    end else begin
      pc_next = step_t'(pc + 4'd1);
    end
  end

  always_comb begin
    unique case (cw.asel)
      A_ITEM:  addr = {IDX_W'(src), IDX_W'(dst)};
      A_IK:    addr = {i, k};
      A_KJ:    addr = {k, j};
      A_IJ:    addr = {i, j};
      A_SWEEP: addr = sweep;
      default: addr = sweep;
    endcase
  end

  always_comb begin
    dist_we = 1'b0;
    via_we  = 1'b0;
    dist_wd = '0;
    via_wd  = '0;
    unique case (cw.wr)
      WR_NONE: begin
      end
      WR_CLEAR: begin
        dist_we = 1'b1;
        via_we  = 1'b1;
        dist_wd = {(sweep[ADDR_W-1:IDX_W] == sweep[IDX_W-1:0]), {DIST_W{1'b0}}};
      end
      WR_EDGE: begin
        dist_we = edge_ok;
        dist_wd = {1'b1, DIST_W'(w_eff)};
      end
      WR_RELAX: begin
        dist_we = better;
        via_we  = better;
        dist_wd = {1'b1, sum_sat};
        via_wd  = {1'b1, k};
      end
    endcase
  end

  assign q_reach   = pair_ok && dist_rd[DIST_W];
  assign q_via     = pair_ok && via_rd[IDX_W];

  always_comb begin
    emit_data = '0;
    emit_data[DIST_W+VIA_FIELD_W+2] = 1'b1;
    if (cw.emit == EM_QUERY) begin
      emit_data[0]          = q_reach;
      emit_data[DIST_W:1]   = q_reach ? dist_rd[DIST_W-1:0] : '0;
      emit_data[DIST_W+1]   = q_via;
      emit_data[DIST_W+VIA_FIELD_W+1:DIST_W+2] =
          q_via ? VIA_FIELD_W'(via_rd[IDX_W-1:0]) : '0;
    end
  end

  apsp_ram #(.DATA_W(DROW_W), .ADDR_W(ADDR_W)) u_dist (
    .clk   (clk),
    .we    (dist_we),
    .addr  (addr),
    .wdata (dist_wd),
    .rdata (dist_rd)
  );

  apsp_ram #(.DATA_W(VROW_W), .ADDR_W(ADDR_W)) u_via (
    .clk   (clk),
    .we    (via_we),
    .addr  (addr),
    .wdata (via_wd),
    .rdata (via_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= S_RST;
      sweep        <= '0;
      out_valid    <= 1'b0;
      vertex_count <= VCOUNT_W'(32);
    end else begin
      pc <= pc_next;
      if (cw.sweep_inc) begin
        sweep <= sweep + 1'b1;
      end
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        vertex_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      src    <= s_axis_tdata[4:0];
      dst    <= s_axis_tdata[9:5];
      weight <= s_axis_tdata[25:10];
    end
    if (emit_fire) begin
      out_data <= emit_data;
    end
    unique case (cw.lat)
      LAT_NONE: begin
      end
      LAT_DIK: begin
        dik_ok  <= dist_rd[DIST_W];
        dik_val <= dist_rd[DIST_W-1:0];
      end
      LAT_DKJ: begin
        dkj_ok  <= dist_rd[DIST_W];
        dkj_val <= dist_rd[DIST_W-1:0];
      end
      default: begin
      end
    endcase
    unique case (cw.k_op)
      CNT_CLR: k <= '0;
      CNT_INC: k <= k + 1'b1;
      default: k <= k;
    endcase
    unique case (cw.i_op)
      CNT_CLR: i <= '0;
      CNT_INC: i <= i + 1'b1;
      default: i <= i;
    endcase
    unique case (cw.j_op)
      CNT_CLR: j <= '0;
      CNT_INC: j <= j + 1'b1;
      default: j <= j;
    endcase
  end

`ifndef NO_ASSERTIONS
  // pivot row and column never change during their own pass
  a_pivot_stable: assert property (@(posedge clk) disable iff (rst)
    (pc == S_JUPD && dist_we) |-> (i != k && j != k))
    else $error("relaxation wrote the pivot row or column");

  // loop counters stay inside the active vertex range
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (pc == S_JUPD) |-> (i <= n_last && j <= n_last && k <= n_last))
    else $error("loop counter beyond active vertex range");

  // inner loop only runs with a reachable first leg
  a_dik_ok: assert property (@(posedge clk) disable iff (rst)
    (pc == S_JUPD) |-> dik_ok)
    else $error("inner loop entered with unreachable first leg");

  // an accepted item keeps the block busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("item accepted while previous one still running");
`endif

endmodule

// ===== bench/all_pairs_shortest_path_checker.sv =====
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_checker
// Watches the configuration, item and result channels of the shortest path
// core. Keeps its own copy of the distance and intermediate tables and updates
// it for every accepted clear, edge and run item. The result expected for each
// item is queued and compared field by field with the results that come back.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [apsp_pkg::VCOUNT_W-1:0]    cfg_data,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [apsp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // src, dst, weight
  input  logic [1:0]                       s_axis_tuser,  // op
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // reachable, distance, has_intermediate, via_vertex, done_res
  input  logic [apsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output int                               answers_seen,
  output int                               answers_owed,
  output int                               mismatches
);
  timeunit 1ns;
  timeprecision 1ps;
  import apsp_pkg::*;

  localparam int NV = 32;

  typedef struct packed {
    logic              reach;
    logic [DIST_W-1:0] path_len;
    logic              has_via;
    logic [4:0]        via;
  } answer_t;

  logic [DIST_W-1:0]   span    [NV][NV];
  bit                  span_ok [NV][NV];
  logic [4:0]          hop     [NV][NV];
  bit                  hop_ok  [NV][NV];
  logic [VCOUNT_W-1:0] vcount;

  answer_t expected_answers[$];
  answer_t want;
  int      errs = 0;

  assign mismatches = errs;

  function automatic int used_vertices();
    if (vcount == 0) return 1;
    if (vcount > NV) return NV;
    return int'(vcount);
  endfunction

  function automatic void clear_graph();
    for (int i = 0; i < NV; i++) begin
      for (int j = 0; j < NV; j++) begin
        span[i][j]    = '0;
        span_ok[i][j] = (i == j);
        hop[i][j]     = '0;
        hop_ok[i][j]  = 1'b0;
      end
    end
  endfunction

  function automatic void relax_graph();
    int n;
    logic [DIST_W:0] total;
    n = used_vertices();
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < n; i++) begin
        if (!span_ok[i][k]) continue;
        for (int j = 0; j < n; j++) begin
          if (!span_ok[k][j]) continue;
          total = {1'b0, span[i][k]} + {1'b0, span[k][j]};
          if (total > {1'b0, DIST_MAX}) total = {1'b0, DIST_MAX};
          if (!span_ok[i][j] || total < {1'b0, span[i][j]}) begin
            span[i][j]    = total[DIST_W-1:0];
            span_ok[i][j] = 1'b1;
            hop[i][j]     = k[4:0];
            hop_ok[i][j]  = 1'b1;
          end
        end
      end
    end
  endfunction

  function automatic answer_t predict_answer(op_t op, logic [4:0] s, logic [4:0] d,
                                             logic [WEIGHT_FIELD_W-1:0] w);
    answer_t a;
    int n;
    a = '0;
    n = used_vertices();
    case (op)
      OP_CLEAR: clear_graph();
      OP_EDGE: begin
        if (s < n && d < n && w != 0) begin
          span[s][d]    = {{(DIST_W-WEIGHT_FIELD_W){1'b0}}, w};
          span_ok[s][d] = 1'b1;
        end
      end
      OP_RUN: relax_graph();
      OP_QUERY: begin
        if (s < n && d < n) begin
          if (span_ok[s][d]) begin
            a.reach    = 1'b1;
            a.path_len = span[s][d];
          end
          if (hop_ok[s][d]) begin
            a.has_via = 1'b1;
            a.via     = hop[s][d];
          end
        end
      end
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_graph();
      vcount = 6'd32;
      expected_answers.delete();
      answers_seen <= 0;
      answers_owed <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_answers.size() == 0) begin
          $error("result with no item waiting: tdata %h", m_axis_tdata);
          errs++;
        end else begin
          want = expected_answers.pop_front();
          if (m_axis_tdata[0] !== want.reach) begin
            $error("reachable expected %0d got %0d", want.reach, m_axis_tdata[0]);
            errs++;
          end
          if (m_axis_tdata[21:1] !== want.path_len) begin
            $error("distance expected %0d got %0d", want.path_len, m_axis_tdata[21:1]);
            errs++;
          end
          if (m_axis_tdata[22] !== want.has_via) begin
            $error("has_intermediate expected %0d got %0d", want.has_via, m_axis_tdata[22]);
            errs++;
          end
          if (m_axis_tdata[27:23] !== want.via) begin
            $error("via_vertex expected %0d got %0d", want.via, m_axis_tdata[27:23]);
            errs++;
          end
          if (m_axis_tdata[28] !== 1'b1) begin
            $error("done_res expected 1 got %0d", m_axis_tdata[28]);
            errs++;
          end
        end
        answers_seen <= answers_seen + 1;
      end
      if (cfg_valid && cfg_ready) vcount = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_answers.insert(expected_answers.size(),
                                predict_answer(op_t'(s_axis_tuser), s_axis_tdata[4:0],
                                               s_axis_tdata[9:5], s_axis_tdata[25:10]));
      end
      answers_owed <= expected_answers.size();
    end
  end

endmodule

// ===== bench/all_pairs_shortest_path_core_tb.sv =====
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_core_tb
// Drives the shortest path core with a short directed sequence (diagonal,
// unreachable pairs, zero and maximum weights, overwrites, repeated runs,
// clear, unused indices, vertex count extremes) and then with random graph
// phases: clear, edges, run, queries, mixed with stray items. Both sides of
// the stream idle at random, with one long output hold-off. Checking is done
// by the checker module instantiated beside the core.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import apsp_pkg::*;

  localparam int CYCLE_LIMIT = 12_000_000;
  localparam int ITEM_TOTAL  = 650;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [VCOUNT_W-1:0]       cfg_data = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_TDATA_W-1:0]     s_axis_tdata = '0;   // src, dst, weight
  logic [1:0]                s_axis_tuser = '0;   // op
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  // reachable, distance, has_intermediate, via_vertex, done_res
  logic [OUT_TDATA_W-1:0]    m_axis_tdata;

  int answers_seen;
  int answers_owed;
  int mismatches;

  int items_sent = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int cycles = 0;

  int inputs_taken = 0;
  int hold_left = 0;
  bit held_once = 1'b0;
  int mode = 0;
  int mode_left = 0;

  all_pairs_shortest_path_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  all_pairs_shortest_path_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .answers_seen  (answers_seen),
    .answers_owed  (answers_owed),
    .mismatches    (mismatches)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // output side: stall patterns plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) inputs_taken <= inputs_taken + 1;
      if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!held_once && inputs_taken == 40) begin
        held_once     <= 1'b1;
        hold_left     <= 400;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      <= $urandom_range(0, 2);
          mode_left <= $urandom_range(20, 120);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic push_item(input op_t op, input logic [4:0] s, input logic [4:0] d,
                           input logic [WEIGHT_FIELD_W-1:0] w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, w, d, s};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (answers_seen != items_sent) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [VCOUNT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly in-range items, some stray ones
  task automatic offer(input op_t op, input int n, input bit wide);
    op_t o;
    logic [4:0] s;
    logic [4:0] d;
    logic [WEIGHT_FIELD_W-1:0] w;
    o = op;
    s = 5'($urandom_range(0, n - 1));
    d = 5'($urandom_range(0, n - 1));
    w = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(1, 16)) :
        16'($urandom_range(0, 65535));
    if ($urandom_range(0, 99) < 15) begin
      o = op_t'($urandom_range(0, 3));
      if (wide && o == OP_RUN) o = OP_QUERY;
      s = 5'($urandom_range(0, 31));
      d = 5'($urandom_range(0, 31));
      w = ($urandom_range(0, 3) == 0) ? '0 : 16'($urandom_range(0, 65535));
    end
    push_item(o, s, d, w);
  endtask

  task automatic run_phase(input logic [VCOUNT_W-1:0] v);
    int n;
    int target;
    int count;
    int runs;
    int edges;
    bit wide;
    n = (v == 0) ? 1 : ((v > 32) ? 32 : int'(v));
    wide = (n >= 16);
    target = wide ? 30 : $urandom_range(30, 50);
    gaps_on = ($urandom_range(0, 3) != 0);
    count = 0;
    runs = 0;
    write_vertex_count(v);
    if (wide || $urandom_range(0, 9) < 6) begin
      push_item(OP_CLEAR, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                16'($urandom_range(0, 65535)));
      count++;
    end
    while (count < target) begin
      edges = wide ? $urandom_range(3, 6) : $urandom_range(1, 2 * n + 1);
      repeat (edges) begin
        offer(OP_EDGE, n, wide);
        count++;
      end
      if (!wide || runs < 2) begin
        offer(OP_RUN, n, wide);
        runs++;
        count++;
      end
      repeat ($urandom_range(2, 8)) begin
        offer(OP_QUERY, n, wide);
        count++;
      end
    end
    settle();
  endtask

  logic [VCOUNT_W-1:0] vc_plan [14] = '{6'd3, 6'd0, 6'd32, 6'd5, 6'd63, 6'd2, 6'd1,
                                        6'd33, 6'd8, 6'd16, 6'd4, 6'd31, 6'd7, 6'd6};

  initial begin
    int phase;
    logic [VCOUNT_W-1:0] v;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_vertex_count(6'd32);

    // diagonal, unreachable, weight extremes, overwrite
    push_item(OP_QUERY, 0, 0, 16'd0);
    push_item(OP_QUERY, 31, 31, 16'hFFFF);
    push_item(OP_QUERY, 0, 31, 16'd0);
    push_item(OP_EDGE, 0, 31, 16'd65535);
    push_item(OP_EDGE, 31, 0, 16'd1);
    push_item(OP_EDGE, 5, 6, 16'd0);
    push_item(OP_QUERY, 5, 6, 16'd0);
    push_item(OP_EDGE, 0, 1, 16'd100);
    push_item(OP_EDGE, 1, 2, 16'd200);
    push_item(OP_EDGE, 0, 2, 16'd500);
    push_item(OP_EDGE, 0, 2, 16'd400);
    push_item(OP_RUN, 0, 0, 16'd0);
    push_item(OP_QUERY, 0, 2, 16'd0);
    push_item(OP_QUERY, 31, 1, 16'd0);
    push_item(OP_QUERY, 0, 31, 16'd0);
    // second run on top of the first
    push_item(OP_EDGE, 2, 0, 16'd7);
    push_item(OP_RUN, 31, 31, 16'hFFFF);
    push_item(OP_QUERY, 2, 1, 16'd0);
    push_item(OP_QUERY, 0, 2, 16'd0);
    push_item(OP_CLEAR, 0, 0, 16'd0);
    push_item(OP_QUERY, 0, 2, 16'd0);
    settle();

    // zero vertex count acts as one
    write_vertex_count(6'd0);
    push_item(OP_EDGE, 0, 0, 16'd9);
    push_item(OP_EDGE, 1, 0, 16'd3);
    push_item(OP_QUERY, 0, 1, 16'd0);
    push_item(OP_RUN, 0, 0, 16'd0);
    push_item(OP_QUERY, 0, 0, 16'd0);
    settle();

    phase = 0;
    while (items_sent < ITEM_TOTAL) begin
      if (phase < 14) v = vc_plan[phase];
      else if ($urandom_range(0, 4) != 0) v = 6'($urandom_range(1, 8));
      else v = 6'($urandom_range(0, 63));
      run_phase(v);
      phase++;
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && answers_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/apsp_pkg.sv
design/apsp_ram.sv
design/all_pairs_shortest_path_core.sv
bench/all_pairs_shortest_path_checker.sv
bench/all_pairs_shortest_path_core_tb.sv
